[src/grfm_pkg.sv]
package grfm_pkg;

  // fixed widths of the internal datapath
  localparam int ANG_W        = 24;
  localparam int DIR_W        = 16;
  localparam int CORDIC_ITERS = 14;

  // angles in 1/4096 degree, cordic values in q.20
  localparam logic signed [ANG_W-1:0] QUARTER_TURN = 24'sd368640;
  localparam logic signed [ANG_W-1:0] CORDIC_GAIN  = 24'sd636750;

  // configuration register indexes
  localparam logic [1:0] CFG_CELL_SIZE = 2'd0;
  localparam logic [1:0] CFG_VIEW_DIST = 2'd1;
  localparam logic [1:0] CFG_FOV       = 2'd2;

  // arctangent table for the rotation steps
  function automatic logic signed [ANG_W-1:0] atan_q(input logic [3:0] i);
    logic signed [ANG_W-1:0] v;
    case (i)
      4'd0:    v = 24'sd184320;
      4'd1:    v = 24'sd108810;
      4'd2:    v = 24'sd57492;
      4'd3:    v = 24'sd29184;
      4'd4:    v = 24'sd14649;
      4'd5:    v = 24'sd7331;
      4'd6:    v = 24'sd3667;
      4'd7:    v = 24'sd1833;
      4'd8:    v = 24'sd917;
      4'd9:    v = 24'sd458;
      4'd10:   v = 24'sd229;
      4'd11:   v = 24'sd115;
      4'd12:   v = 24'sd57;
      4'd13:   v = 24'sd29;
      default: v = 24'sd0;
    endcase
    return v;
  endfunction

  typedef enum logic [3:0] {
    S_CLEAR, S_IDLE, S_FDIV, S_RAY, S_NORM, S_CORDIC, S_DIR,
    S_CHK, S_SAMP, S_PDIV, S_LOOK, S_TEST, S_EMIT
  } state_t;

  typedef enum logic [3:0] {
    OP_NOP, OP_CLR, OP_WRITE, OP_LOAD, OP_FDIV, OP_RAY, OP_NORM, OP_CINIT,
    OP_CORD, OP_DIR, OP_MUL, OP_SAMP, OP_PDIV, OP_LOOK, OP_ADV, OP_NEXT
  } op_t;

  typedef struct packed {
    logic clr_done;
    logic fdiv_done;
    logic norm_ok;
    logic cord_done;
    logic pdiv_done;
    logic d_done;
    logic wall_hit;
    logic last_ray;
  } status_t;

endpackage

[src/grfm_ctrl.sv]
module grfm_ctrl (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              in_tvalid,
  input  logic              in_func,
  input  logic              out_tready,
  input  grfm_pkg::status_t st,
  output logic              in_tready,
  output logic              out_tvalid,
  output grfm_pkg::op_t     op
);

  grfm_pkg::state_t state_r, state_nxt;

  // state register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= grfm_pkg::S_CLEAR;
    end else begin
      state_r <= state_nxt;
    end
  end

  // next state and commands
  always_comb begin
    state_nxt  = state_r;
    op         = grfm_pkg::OP_NOP;
    in_tready  = 1'b0;
    out_tvalid = 1'b0;
    case (state_r)
      grfm_pkg::S_CLEAR: begin
        op = grfm_pkg::OP_CLR;
        if (st.clr_done) state_nxt = grfm_pkg::S_IDLE;
      end
      grfm_pkg::S_IDLE: begin
        in_tready = 1'b1;
        if (in_tvalid) begin
          if (in_func) begin
            op        = grfm_pkg::OP_LOAD;
            state_nxt = grfm_pkg::S_FDIV;
          end else begin
            op = grfm_pkg::OP_WRITE;
          end
        end
      end
      grfm_pkg::S_FDIV: begin
        op = grfm_pkg::OP_FDIV;
        if (st.fdiv_done) state_nxt = grfm_pkg::S_RAY;
      end
      grfm_pkg::S_RAY: begin
        op        = grfm_pkg::OP_RAY;
        state_nxt = grfm_pkg::S_NORM;
      end
      grfm_pkg::S_NORM: begin
        if (st.norm_ok) begin
          op        = grfm_pkg::OP_CINIT;
          state_nxt = grfm_pkg::S_CORDIC;
        end else begin
          op = grfm_pkg::OP_NORM;
        end
      end
      grfm_pkg::S_CORDIC: begin
        op = grfm_pkg::OP_CORD;
        if (st.cord_done) state_nxt = grfm_pkg::S_DIR;
      end
      grfm_pkg::S_DIR: begin
        op        = grfm_pkg::OP_DIR;
        state_nxt = grfm_pkg::S_CHK;
      end
      grfm_pkg::S_CHK: begin
        if (st.d_done) begin
          state_nxt = grfm_pkg::S_EMIT;
        end else begin
          op        = grfm_pkg::OP_MUL;
          state_nxt = grfm_pkg::S_SAMP;
        end
      end
      grfm_pkg::S_SAMP: begin
        op        = grfm_pkg::OP_SAMP;
        state_nxt = grfm_pkg::S_PDIV;
      end
      grfm_pkg::S_PDIV: begin
        op = grfm_pkg::OP_PDIV;
        if (st.pdiv_done) state_nxt = grfm_pkg::S_LOOK;
      end
      grfm_pkg::S_LOOK: begin
        op        = grfm_pkg::OP_LOOK;
        state_nxt = grfm_pkg::S_TEST;
      end
      grfm_pkg::S_TEST: begin
        if (st.wall_hit) begin
          state_nxt = grfm_pkg::S_EMIT;
        end else begin
          op        = grfm_pkg::OP_ADV;
          state_nxt = grfm_pkg::S_CHK;
        end
      end
      grfm_pkg::S_EMIT: begin
        out_tvalid = 1'b1;
        if (out_tready) begin
          if (st.last_ray) begin
            state_nxt = grfm_pkg::S_IDLE;
          end else begin
            op        = grfm_pkg::OP_NEXT;
            state_nxt = grfm_pkg::S_RAY;
          end
        end
      end
      default: state_nxt = grfm_pkg::S_CLEAR;
    endcase
  end

endmodule

[src/grfm_dp.sv]
module grfm_dp #(
  parameter int NUM_RAYS   = 40,
  parameter int GRID_DIM   = 64,
  parameter int MARCH_STEP = 4
) (
  input  logic                     clk,
  input  logic                     rst_n,
  input  grfm_pkg::op_t            op,
  input  logic                     cfg_we,
  input  logic [1:0]               cfg_addr,
  input  logic [12:0]              cfg_wdata,
  input  logic [5:0]               in_cell_col,
  input  logic [5:0]               in_cell_row,
  input  logic                     in_wall_bit,
  input  logic [15:0]              in_origin_x,
  input  logic [15:0]              in_origin_y,
  input  logic [12:0]              in_view_angle,
  output logic [17:0]              end_x,
  output logic [17:0]              end_y,
  output logic [5:0]               ray_index,
  output grfm_pkg::status_t        st
);

  localparam int RW = (GRID_DIM > 1) ? $clog2(GRID_DIM) : 1;
  localparam logic [7:0]    NR8     = 8'(NUM_RAYS);
  localparam logic [8:0]    GD9     = 9'(GRID_DIM);
  localparam logic [12:0]   GD13    = 13'(GRID_DIM);
  localparam logic [12:0]   STEP13  = 13'(MARCH_STEP);
  localparam logic [5:0]    LAST6   = 6'(NUM_RAYS - 1);
  localparam logic [RW-1:0] LASTROW = RW'(GRID_DIM - 1);
  localparam logic [4:0]    CORD_LAST = 5'(grfm_pkg::CORDIC_ITERS - 1);
  // reciprocal of the ray count, exact for 21-bit dividends
  localparam int            FQ_SH   = 27;
  localparam logic [27:0]   FRECIP  =
    28'(((64'd1 << FQ_SH) + 64'(NUM_RAYS) - 64'd1) / 64'(NUM_RAYS));
  localparam logic [27:0]   NR28    = 28'(NUM_RAYS);

  // round q.20 to q1.14 and clamp to plus or minus one
  function automatic logic signed [15:0] to_q14(input logic signed [23:0] v);
    logic signed [23:0] t;
    t = (v + 24'sd32) >>> 6;
    if (t > 24'sd16384) t = 24'sd16384;
    if (t < -24'sd16384) t = -24'sd16384;
    return t[15:0];
  endfunction

  // configuration and control registers
  logic [7:0]     cs_r;
  logic [11:0]    vd_r;
  logic [12:0]    fov_r;
  logic [RW-1:0]  clr_r;
  logic [4:0]     it_r;

  // payload registers
  logic [15:0]             ox_r, oy_r;
  logic [12:0]             va_r;
  logic [20:0]             fnum_r;
  logic [7:0]              frem_r;
  logic [21:0]             qacc_r;
  logic [7:0]              racc_r;
  logic [5:0]              ray_r;
  logic signed [23:0]      ang_r;
  logic [1:0]              quad_r;
  logic signed [23:0]      cx_r, cy_r, cz_r;
  logic signed [15:0]      dc_r, ds_r;
  logic [12:0]             d_r;
  logic signed [29:0]      px_r, py_r;
  logic signed [18:0]      ex_r, ey_r;
  logic [12:0]             dvx_r, dvy_r;
  logic [8:0]              rmx_r, rmy_r;
  logic                    negx_r, negy_r;
  logic                    oob_r;
  logic [RW-1:0]           colsel_r;
  logic [GRID_DIM-1:0]     rowd_r;
  logic [GRID_DIM-1:0]     grid_mem [GRID_DIM];

  // combinational helpers
  logic [7:0]          cs_eff;
  logic [8:0]          cs9;
  logic [20:0]         fx;
  logic [48:0]         fprod;
  logic [27:0]         fqn;
  logic [20:0]         fdiff;
  logic [3:0]          sh;
  logic signed [23:0]  xs, ys, at;
  logic signed [15:0]  cq, sq;
  logic signed [29:0]  tx, ty;
  logic signed [18:0]  ex_nxt, ey_nxt, axe, aye;
  logic [8:0]          rmx_sh, rmy_sh;
  logic                gex, gey;
  logic                offx, offy;
  logic [8:0]          wcol9, wrow9;
  logic                wr_ok;
  logic [7:0]          rsum;
  logic [7:0]          racc_nxt;
  logic [21:0]         qacc_nxt;
  logic signed [23:0]  base;

  assign cs_eff  = (cs_r == 8'd0) ? 8'd1 : cs_r;
  assign cs9     = {1'b0, cs_eff};
  // fan step: quotient by reciprocal multiply, remainder on the next cycle
  assign fx      = {fov_r, 8'd0};
  assign fprod   = {28'd0, fx} * {21'd0, FRECIP};
  assign fqn     = {7'd0, fnum_r} * NR28;
  assign fdiff   = fx - fqn[20:0];
  assign sh      = it_r[3:0];
  assign xs      = cx_r >>> sh;
  assign ys      = cy_r >>> sh;
  assign at      = grfm_pkg::atan_q(sh);
  assign cq      = to_q14(cx_r);
  assign sq      = to_q14(cy_r);
  assign tx      = (px_r + 30'sd512) >>> 10;
  assign ty      = (py_r + 30'sd512) >>> 10;
  assign ex_nxt  = $signed({3'b000, ox_r}) + tx[18:0];
  assign ey_nxt  = $signed({3'b000, oy_r}) + ty[18:0];
  assign axe     = ex_nxt[18] ? -ex_nxt : ex_nxt;
  assign aye     = ey_nxt[18] ? -ey_nxt : ey_nxt;
  assign rmx_sh  = {rmx_r[7:0], dvx_r[12]};
  assign rmy_sh  = {rmy_r[7:0], dvy_r[12]};
  assign gex     = rmx_sh >= cs9;
  assign gey     = rmy_sh >= cs9;
  assign offx    = (negx_r && (dvx_r != 13'd0)) || (dvx_r >= GD13);
  assign offy    = (negy_r && (dvy_r != 13'd0)) || (dvy_r >= GD13);
  assign wcol9   = {3'b000, in_cell_col};
  assign wrow9   = {3'b000, in_cell_row};
  assign wr_ok   = (wcol9 < GD9) && (wrow9 < GD9);
  assign base    = $signed({3'b000, va_r, 8'd0}) - $signed({4'b0000, fov_r, 7'd0});

  // fan angle step accumulator: quotient plus remainder below the ray count
  always_comb begin
    rsum     = racc_r + frem_r;
    racc_nxt = rsum;
    qacc_nxt = qacc_r + {1'b0, fnum_r};
    if (rsum >= NR8) begin
      racc_nxt = rsum - NR8;
      qacc_nxt = qacc_r + {1'b0, fnum_r} + 22'd1;
    end
  end

  // status to the controller
  assign st.clr_done  = clr_r == LASTROW;
  assign st.fdiv_done = it_r == 5'd1;
  assign st.norm_ok   = !ang_r[23] && (ang_r < grfm_pkg::QUARTER_TURN);
  assign st.cord_done = it_r == CORD_LAST;
  assign st.pdiv_done = it_r == 5'd12;
  assign st.d_done    = d_r >= {1'b0, vd_r};
  assign st.wall_hit  = oob_r || rowd_r[colsel_r];
  assign st.last_ray  = ray_r == LAST6;

  assign end_x     = ex_r[17:0];
  assign end_y     = ey_r[17:0];
  assign ray_index = ray_r;

  // configuration registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cs_r  <= 8'd32;
      vd_r  <= 12'd200;
      fov_r <= 13'd960;
    end else if (cfg_we) begin
      case (cfg_addr)
        grfm_pkg::CFG_CELL_SIZE: cs_r  <= cfg_wdata[7:0];
        grfm_pkg::CFG_VIEW_DIST: vd_r  <= cfg_wdata[11:0];
        grfm_pkg::CFG_FOV:       fov_r <= cfg_wdata;
        default: ;
      endcase
    end
  end

  // clear row counter and shared iteration counter
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      clr_r <= '0;
      it_r  <= '0;
    end else begin
      if (op == grfm_pkg::OP_CLR) clr_r <= clr_r + RW'(1);
      if (op == grfm_pkg::OP_FDIV || op == grfm_pkg::OP_CORD ||
          op == grfm_pkg::OP_PDIV) begin
        it_r <= it_r + 5'd1;
      end else begin
        it_r <= '0;
      end
    end
  end

  // wall grid, one row per word
  always_ff @(posedge clk) begin
    if (op == grfm_pkg::OP_CLR) begin
      grid_mem[clr_r] <= '0;
    end else if (op == grfm_pkg::OP_WRITE && wr_ok) begin
      grid_mem[wrow9[RW-1:0]][wcol9[RW-1:0]] <= in_wall_bit;
    end
    if (op == grfm_pkg::OP_LOOK) rowd_r <= grid_mem[dvy_r[RW-1:0]];
  end

  // cast datapath
  always_ff @(posedge clk) begin
    case (op)
      grfm_pkg::OP_LOAD: begin
        ox_r   <= in_origin_x;
        oy_r   <= in_origin_y;
        va_r   <= in_view_angle;
        frem_r <= '0;
        qacc_r <= '0;
        racc_r <= '0;
        ray_r  <= '0;
      end
      grfm_pkg::OP_FDIV: begin
        if (it_r == 5'd0) begin
          fnum_r <= fprod[FQ_SH+20:FQ_SH];
        end else begin
          frem_r <= fdiff[7:0];
        end
      end
      grfm_pkg::OP_RAY: begin
        ang_r  <= base + $signed({2'b00, qacc_r});
        quad_r <= 2'd0;
        ex_r   <= $signed({3'b000, ox_r});
        ey_r   <= $signed({3'b000, oy_r});
        d_r    <= '0;
      end
      grfm_pkg::OP_NORM: begin
        if (ang_r[23]) begin
          ang_r  <= ang_r + grfm_pkg::QUARTER_TURN;
          quad_r <= quad_r - 2'd1;
        end else begin
          ang_r  <= ang_r - grfm_pkg::QUARTER_TURN;
          quad_r <= quad_r + 2'd1;
        end
      end
      grfm_pkg::OP_CINIT: begin
        cx_r <= grfm_pkg::CORDIC_GAIN;
        cy_r <= '0;
        cz_r <= ang_r;
      end
      grfm_pkg::OP_CORD: begin
        if (!cz_r[23]) begin
          cx_r <= cx_r - ys;
          cy_r <= cy_r + xs;
          cz_r <= cz_r - at;
        end else begin
          cx_r <= cx_r + ys;
          cy_r <= cy_r - xs;
          cz_r <= cz_r + at;
        end
      end
      grfm_pkg::OP_DIR: begin
        case (quad_r)
          2'd0: begin dc_r <= cq;  ds_r <= sq;  end
          2'd1: begin dc_r <= -sq; ds_r <= cq;  end
          2'd2: begin dc_r <= -cq; ds_r <= -sq; end
          default: begin dc_r <= sq; ds_r <= -cq; end
        endcase
      end
      grfm_pkg::OP_MUL: begin
        px_r <= 30'(dc_r) * 30'($signed({1'b0, d_r}));
        py_r <= 30'(ds_r) * 30'($signed({1'b0, d_r}));
      end
      grfm_pkg::OP_SAMP: begin
        ex_r   <= ex_nxt;
        ey_r   <= ey_nxt;
        negx_r <= ex_nxt[18];
        negy_r <= ey_nxt[18];
        dvx_r  <= axe[16:4];
        dvy_r  <= aye[16:4];
        rmx_r  <= '0;
        rmy_r  <= '0;
      end
      grfm_pkg::OP_PDIV: begin
        rmx_r <= gex ? (rmx_sh - cs9) : rmx_sh;
        rmy_r <= gey ? (rmy_sh - cs9) : rmy_sh;
        dvx_r <= {dvx_r[11:0], gex};
        dvy_r <= {dvy_r[11:0], gey};
      end
      grfm_pkg::OP_LOOK: begin
        oob_r    <= offx || offy;
        colsel_r <= dvx_r[RW-1:0];
      end
      grfm_pkg::OP_ADV: begin
        d_r <= d_r + STEP13;
      end
      grfm_pkg::OP_NEXT: begin
        ray_r  <= ray_r + 6'd1;
        racc_r <= racc_nxt;
        qacc_r <= qacc_nxt;
      end
      default: ;
    endcase
  end

endmodule

[src/grid_ray_fan_marcher_unit.sv]
// Ray fan marcher over a one-bit wall grid. A word with tuser low writes one
// grid cell. A word with tuser high casts a fan of NUM_RAYS rays from the
// given origin and returns one word per ray, tlast on the final one. After
// reset the grid is cleared one row per cycle, all GRID_DIM rows, before the
// first word is taken. A cast first sets up the fan step (reciprocal
// multiply, then remainder), then per ray starts the ray, reduces the angle
// into one quadrant, runs the iterative cordic unit and rounds the
// direction, then per march sample multiplies, samples, divides the 13-bit
// sample coordinates bit-serially by the cell size, reads the grid row and
// tests; a final check ends the march when it runs out, and the result is
// offered and held until tready.
module grid_ray_fan_marcher_unit #(
  parameter int NUM_RAYS   = 40,
  parameter int GRID_DIM   = 64,
  parameter int MARCH_STEP = 4
) (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        cfg_we,
  input  logic [1:0]  cfg_addr,
  input  logic [12:0] cfg_wdata,
  input  logic        in_tvalid,
  output logic        in_tready,
  // cell_col, cell_row, wall_bit, origin_x, origin_y, view_angle, zero pad
  input  logic [63:0] in_tdata,
  // func
  input  logic        in_tuser,
  output logic        out_tvalid,
  input  logic        out_tready,
  // end_x, end_y, ray_index, zero pad
  output logic [47:0] out_tdata,
  output logic        out_tlast
);

  grfm_pkg::op_t     op;
  grfm_pkg::status_t st;
  logic [17:0]       end_x, end_y;
  logic [5:0]        ray_index;

  // controller
  grfm_ctrl u_ctrl (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tvalid  (in_tvalid),
    .in_func    (in_tuser),
    .out_tready (out_tready),
    .st         (st),
    .in_tready  (in_tready),
    .out_tvalid (out_tvalid),
    .op         (op)
  );

  // datapath
  grfm_dp #(
    .NUM_RAYS   (NUM_RAYS),
    .GRID_DIM   (GRID_DIM),
    .MARCH_STEP (MARCH_STEP)
  ) u_dp (
    .clk           (clk),
    .rst_n         (rst_n),
    .op            (op),
    .cfg_we        (cfg_we),
    .cfg_addr      (cfg_addr),
    .cfg_wdata     (cfg_wdata),
    .in_cell_col   (in_tdata[5:0]),
    .in_cell_row   (in_tdata[11:6]),
    .in_wall_bit   (in_tdata[12]),
    .in_origin_x   (in_tdata[28:13]),
    .in_origin_y   (in_tdata[44:29]),
    .in_view_angle (in_tdata[57:45]),
    .end_x         (end_x),
    .end_y         (end_y),
    .ray_index     (ray_index),
    .st            (st)
  );

  // result word packing
  assign out_tdata = {6'd0, ray_index, end_y, end_x};
  assign out_tlast = st.last_ray;

  // no input is taken while a result is offered
  a_no_overlap: assert property (@(posedge clk) disable iff (!rst_n)
    !(in_tready && out_tvalid))
    else $error("input ready while result pending");

  // a cast word closes the input side
  a_cast_busy: assert property (@(posedge clk) disable iff (!rst_n)
    (in_tvalid && in_tready && in_tuser) |=> !in_tready)
    else $error("input ready right after cast");

  // a cell write keeps the block idle
  a_write_idle: assert property (@(posedge clk) disable iff (!rst_n)
    (in_tvalid && in_tready && !in_tuser) |=> in_tready)
    else $error("write did not return to idle");

  // tlast marks the highest ray index
  a_last_index: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid |-> (out_tlast == (ray_index == 6'(NUM_RAYS - 1))))
    else $error("tlast and ray index disagree");

endmodule
